>>> rtl/core/fnr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnr_pkg
// Shared widths, register indexes and microcode for the FitzHugh-Nagumo
// RK4 step block.
// ----------------------------------------------------------------------------
package fnr_pkg;

	localparam int DATA_W    = 32;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int IDX_W     = 6;

	localparam logic [CFG_IDX_W-1:0] CFG_COEF_A    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_B    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_TAU   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_V    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_W    = 3'd5;

	localparam logic [30:0] INV_TAU_RST   = 31'd16777216;
	localparam logic [30:0] STEP_SIZE_RST = 31'd167772;

	localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

	localparam logic [1:0] LAST_STAGE = 2'd3;

	// micro-op kinds of the shared unit
	typedef enum logic [2:0] {
		K_MUL,   // product register <= a * b
		K_SH24,  // dst <= round(product / 2^24), saturated
		K_SH25,  // dst <= round(product / 2^25), saturated
		K_D6,    // start round(product / (6 * 2^24))
		K_DIV,   // six quotient bits of the divide by three
		K_DIVW,  // dst <= quotient
		K_ADD,   // dst <= sat(a + b)
		K_SUB    // dst <= sat(a - b)
	} kind_t;

	typedef enum logic [3:0] {
		S_ZERO, S_V0, S_W0, S_STIM, S_MV, S_MW, S_KV, S_KW,
		S_SV, S_SW, S_T1, S_T2, S_A, S_B, S_TAU, S_STEP
	} src_t;

	typedef enum logic [3:0] {
		D_NONE, D_V0, D_W0, D_MV, D_MW, D_KV, D_KW, D_SV, D_SW, D_T1, D_T2
	} dst_t;

	typedef struct packed {
		kind_t kind;
		src_t  src_a;
		src_t  src_b;
		dst_t  dst;
		logic  last;
	} uop_t;

	// Per RK stage: slope at (mv, mw), weighted sum update, then either the
	// next evaluation point or, on the last stage, the final update.
	function automatic uop_t fnr_uop(input logic [1:0] stage, input logic [IDX_W-1:0] idx);
		uop_t  u;
		logic  first;
		logic  dbl;
		kind_t sk;
		first = (stage == 2'd0);
		dbl   = (stage == 2'd1) || (stage == 2'd2);
		sk    = (stage == 2'd2) ? K_SH24 : K_SH25;
		u     = '{K_ADD, S_ZERO, S_ZERO, D_NONE, 1'b1};
		if (idx < 6'd17) begin
			case (idx)
				6'd0:    u = '{K_MUL,  S_MV,   S_MV,   D_NONE, 1'b0};
				6'd1:    u = '{K_SH24, S_ZERO, S_ZERO, D_T1,   1'b0};
				6'd2:    u = '{K_MUL,  S_T1,   S_MV,   D_NONE, 1'b0};
				6'd3:    u = '{K_SH24, S_ZERO, S_ZERO, D_T1,   1'b0};
				6'd4:    u = '{K_SUB,  S_MV,   S_T1,   D_T1,   1'b0};
				6'd5:    u = '{K_SUB,  S_T1,   S_MW,   D_T1,   1'b0};
				6'd6:    u = '{K_ADD,  S_T1,   S_STIM, D_KV,   1'b0};
				6'd7:    u = '{K_MUL,  S_B,    S_MW,   D_NONE, 1'b0};
				6'd8:    u = '{K_SH24, S_ZERO, S_ZERO, D_T2,   1'b0};
				6'd9:    u = '{K_ADD,  S_MV,   S_A,    D_T1,   1'b0};
				6'd10:   u = '{K_SUB,  S_T1,   S_T2,   D_T1,   1'b0};
				6'd11:   u = '{K_MUL,  S_T1,   S_TAU,  D_NONE, 1'b0};
				6'd12:   u = '{K_SH24, S_ZERO, S_ZERO, D_KW,   1'b0};
				6'd13:   u = '{K_ADD, first ? S_ZERO : S_SV, S_KV, D_SV, 1'b0};
				6'd14:   u = '{K_ADD, first ? S_ZERO : S_SW, S_KW, D_SW, 1'b0};
				6'd15:   u = '{K_ADD, S_SV, dbl ? S_KV : S_ZERO, D_SV, 1'b0};
				6'd16:   u = '{K_ADD, S_SW, dbl ? S_KW : S_ZERO, D_SW, 1'b0};
				default: u = '{K_ADD, S_ZERO, S_ZERO, D_NONE, 1'b1};
			endcase
		end else if (stage != LAST_STAGE) begin
			case (idx)
				6'd17:   u = '{K_MUL, S_KV,   S_STEP, D_NONE, 1'b0};
				6'd18:   u = '{sk,    S_ZERO, S_ZERO, D_T1,   1'b0};
				6'd19:   u = '{K_ADD, S_V0,   S_T1,   D_MV,   1'b0};
				6'd20:   u = '{K_MUL, S_KW,   S_STEP, D_NONE, 1'b0};
				6'd21:   u = '{sk,    S_ZERO, S_ZERO, D_T1,   1'b0};
				6'd22:   u = '{K_ADD, S_W0,   S_T1,   D_MW,   1'b1};
				default: u = '{K_ADD, S_ZERO, S_ZERO, D_NONE, 1'b1};
			endcase
		end else begin
			case (idx) inside
				6'd17:           u = '{K_MUL,  S_SV,   S_STEP, D_NONE, 1'b0};
				6'd18:           u = '{K_D6,   S_ZERO, S_ZERO, D_NONE, 1'b0};
				[6'd19:6'd24]:   u = '{K_DIV,  S_ZERO, S_ZERO, D_NONE, 1'b0};
				6'd25:           u = '{K_DIVW, S_ZERO, S_ZERO, D_T1,   1'b0};
				6'd26:           u = '{K_ADD,  S_V0,   S_T1,   D_V0,   1'b0};
				6'd27:           u = '{K_MUL,  S_SW,   S_STEP, D_NONE, 1'b0};
				6'd28:           u = '{K_D6,   S_ZERO, S_ZERO, D_NONE, 1'b0};
				[6'd29:6'd34]:   u = '{K_DIV,  S_ZERO, S_ZERO, D_NONE, 1'b0};
				6'd35:           u = '{K_DIVW, S_ZERO, S_ZERO, D_T1,   1'b0};
				6'd36:           u = '{K_ADD,  S_W0,   S_T1,   D_W0,   1'b1};
				default:         u = '{K_ADD,  S_ZERO, S_ZERO, D_NONE, 1'b1};
			endcase
		end
		return u;
	endfunction

endpackage

>>> rtl/core/fnr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnr_if
// Valid/ready channels of the RK4 step block: stimulus in, result out.
// ----------------------------------------------------------------------------
interface fnr_in_if;
	import fnr_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     op;
	logic signed [DATA_W-1:0] term;
	logic                     last_term;

	modport source(output valid, op, term, last_term, input ready);
	modport sink(input valid, op, term, last_term, output ready);
endinterface

interface fnr_out_if;
	import fnr_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] membrane;
	logic signed [DATA_W-1:0] recovery;
	logic                     saturated;

	modport source(output valid, membrane, recovery, saturated, input ready);
	modport sink(input valid, membrane, recovery, saturated, output ready);
endinterface

>>> rtl/core/fitzhugh_nagumo_rk4_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fitzhugh_nagumo_rk4_step
// One FitzHugh-Nagumo neuron: sums stimulus terms, then advances v and w by
// one classical RK4 step in signed Q8.24 with saturation.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  stim      in   valid / ready    op, term, last_term
//  result    out  valid / ready    membrane, recovery, saturated
//  cfg       in   cfg_wr_en        cfg_index, cfg_data (no read-back)
//
//  A stimulus term without last mark or a restart is taken while idle and
//  leaves the block ready. A last term runs 106 micro-ops through the one
//  shared 32x32 multiplier, adder and divide-by-three digit unit, then its
//  result is loaded into the output register.
//  Reset clears state, sum and configuration to their reset values.
//  A pending result does not stop new requests; a step finishing while the
//  output register is full waits there until it drains.
// ----------------------------------------------------------------------------
module fitzhugh_nagumo_rk4_step (
	input  logic                            clk,
	input  logic                            arst_n,
	fnr_in_if.sink                          stim,
	fnr_out_if.source                       result,
	input  logic                            cfg_wr_en,
	input  logic [fnr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fnr_pkg::CFG_W-1:0]       cfg_data
);
	import fnr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	localparam logic signed [65:0] D6_BIAS = (66'sd3 <<< 56) + (66'sd3 <<< 24);
	localparam logic signed [65:0] D6_TOP  = 66'sd3 <<< 57;

	state_t state_q;
	logic [1:0]       stage_q;
	logic [IDX_W-1:0] idx_q;
	logic             sat_q;
	logic             out_valid_q;

	logic signed [DATA_W-1:0] coef_a_q, coef_b_q, init_v_q, init_w_q;
	logic [30:0]              inv_tau_q, step_q;

	logic signed [DATA_W-1:0] v0_q, w0_q, stim_q;
	logic signed [DATA_W-1:0] mv_q, mw_q, kv_q, kw_q, sv_q, sw_q, t1_q, t2_q;
	logic signed [63:0]       p_q;
	logic [35:0]              nq_q;
	logic [1:0]               rem_q;
	logic                     dsat_q, dneg_q;

	logic signed [DATA_W-1:0] out_v_q, out_w_q;
	logic                     out_sat_q;

	uop_t                     uop;
	logic                     in_acc, run, start, out_free;
	logic signed [32:0]       sum33;
	logic signed [DATA_W-1:0] new_sum;
	logic signed [DATA_W-1:0] a_val, b_val;
	logic signed [63:0]       prod;
	logic                     p_neg;
	logic signed [63:0]       rsum, q64;
	logic signed [32:0]       as33;
	logic signed [65:0]       dsum;
	logic                     d_sat;
	logic [35:0]              nq_next;
	logic [1:0]               rem_next;
	logic [2:0]               dv_t3;
	logic [33:0]              quo34;
	logic signed [DATA_W-1:0] res_val;
	logic                     res_sat;

	assign stim.ready       = (state_q == ST_IDLE);
	assign result.valid     = out_valid_q;
	assign result.membrane  = out_v_q;
	assign result.recovery  = out_w_q;
	assign result.saturated = out_sat_q;

	assign in_acc   = stim.valid && stim.ready;
	assign start    = in_acc && !stim.op && stim.last_term;
	assign run      = (state_q == ST_RUN);
	assign out_free = !out_valid_q || result.ready;
	assign uop      = fnr_uop(stage_q, idx_q);

	// stimulus sum saturates without touching the result flag
	assign sum33   = {stim_q[31], stim_q} + {stim.term[31], stim.term};
	assign new_sum = (sum33[32] != sum33[31]) ? (sum33[32] ? S32_MIN : S32_MAX)
	                                          : sum33[31:0];

	function automatic logic signed [DATA_W-1:0] pick(
		input src_t s,
		input logic signed [DATA_W-1:0] v0, w0, st, mv, mw, kv, kw, sv, sw, t1, t2,
		input logic signed [DATA_W-1:0] ca, cb,
		input logic [30:0] tau, h
	);
		logic signed [DATA_W-1:0] r;
		case (s)
			S_ZERO:  r = '0;
			S_V0:    r = v0;
			S_W0:    r = w0;
			S_STIM:  r = st;
			S_MV:    r = mv;
			S_MW:    r = mw;
			S_KV:    r = kv;
			S_KW:    r = kw;
			S_SV:    r = sv;
			S_SW:    r = sw;
			S_T1:    r = t1;
			S_T2:    r = t2;
			S_A:     r = ca;
			S_B:     r = cb;
			S_TAU:   r = {1'b0, tau};
			S_STEP:  r = {1'b0, h};
			default: r = '0;
		endcase
		return r;
	endfunction

	assign a_val = pick(uop.src_a, v0_q, w0_q, stim_q, mv_q, mw_q, kv_q, kw_q, sv_q, sw_q,
	                    t1_q, t2_q, coef_a_q, coef_b_q, inv_tau_q, step_q);
	assign b_val = pick(uop.src_b, v0_q, w0_q, stim_q, mv_q, mw_q, kv_q, kw_q, sv_q, sw_q,
	                    t1_q, t2_q, coef_a_q, coef_b_q, inv_tau_q, step_q);

	assign prod  = 64'(a_val) * 64'(b_val);
	assign p_neg = p_q[63];

	// round half away from zero: floor((p + half - neg) / 2^s)
	always_comb begin
		if (uop.kind == K_SH25) begin
			rsum = p_q + 64'sd16777216 - {63'd0, p_neg};
			q64  = rsum >>> 25;
		end else begin
			rsum = p_q + 64'sd8388608 - {63'd0, p_neg};
			q64  = rsum >>> 24;
		end
	end

	assign as33 = (uop.kind == K_SUB) ? ({a_val[31], a_val} - {b_val[31], b_val})
	                                  : ({a_val[31], a_val} + {b_val[31], b_val});

	// p / (3 * 2^25) with an offset of 2^31 quotient units, so the
	// dividend is non-negative whenever the quotient is in range
	assign dsum  = {{2{p_q[63]}}, p_q} + D6_BIAS - {65'd0, p_neg};
	assign d_sat = dsum[65] || (dsum >= D6_TOP);

	always_comb begin
		nq_next  = nq_q;
		rem_next = rem_q;
		dv_t3    = '0;
		for (int i = 0; i < 6; i++) begin
			dv_t3   = {rem_next, nq_next[35]};
			nq_next = {nq_next[34:0], 1'b0};
			if (dv_t3 >= 3'd3) begin
				rem_next   = 2'(dv_t3 - 3'd3);
				nq_next[0] = 1'b1;
			end else begin
				rem_next = dv_t3[1:0];
			end
		end
	end

	assign quo34 = {1'b0, nq_q[32:0]} - 34'h0_8000_0000;

	always_comb begin
		res_val = '0;
		res_sat = 1'b0;
		case (uop.kind)
			K_SH24, K_SH25: begin
				if (q64[63:31] != {33{q64[63]}}) begin
					res_val = q64[63] ? S32_MIN : S32_MAX;
					res_sat = 1'b1;
				end else begin
					res_val = q64[31:0];
				end
			end
			K_ADD, K_SUB: begin
				if (as33[32] != as33[31]) begin
					res_val = as33[32] ? S32_MIN : S32_MAX;
					res_sat = 1'b1;
				end else begin
					res_val = as33[31:0];
				end
			end
			K_D6:    res_sat = d_sat;
			K_DIVW:  res_val = dsat_q ? (dneg_q ? S32_MIN : S32_MAX) : quo34[31:0];
			default: ;
		endcase
	end

	// control, configuration and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			stage_q     <= '0;
			idx_q       <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
			coef_a_q    <= '0;
			coef_b_q    <= '0;
			inv_tau_q   <= INV_TAU_RST;
			step_q      <= STEP_SIZE_RST;
			init_v_q    <= '0;
			init_w_q    <= '0;
			v0_q        <= '0;
			w0_q        <= '0;
			stim_q      <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					CFG_COEF_A:    coef_a_q  <= cfg_data;
					CFG_COEF_B:    coef_b_q  <= cfg_data;
					CFG_INV_TAU:   inv_tau_q <= cfg_data[30:0];
					CFG_STEP_SIZE: step_q    <= cfg_data[30:0];
					CFG_INIT_V:    init_v_q  <= cfg_data;
					CFG_INIT_W:    init_w_q  <= cfg_data;
					default: ;
				endcase
			end

			// a finished step refills the output register as it drains
			if (state_q == ST_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (stim.op) begin
							v0_q   <= init_v_q;
							w0_q   <= init_w_q;
							stim_q <= '0;
						end else begin
							stim_q <= new_sum;
						end
						if (start) begin
							state_q <= ST_RUN;
							stage_q <= '0;
							idx_q   <= '0;
							sat_q   <= 1'b0;
						end
					end
				end
				ST_RUN: begin
					if (res_sat)
						sat_q <= 1'b1;
					if (uop.dst == D_V0)
						v0_q <= res_val;
					if (uop.dst == D_W0)
						w0_q <= res_val;
					if (uop.last) begin
						idx_q <= '0;
						if (stage_q == LAST_STAGE) begin
							state_q <= ST_FIN;
							stim_q  <= '0;
						end else begin
							stage_q <= stage_q + 2'd1;
						end
					end else begin
						idx_q <= idx_q + 6'd1;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath working registers
	always_ff @(posedge clk) begin
		if (start) begin
			mv_q <= v0_q;
			mw_q <= w0_q;
		end
		if (state_q == ST_FIN && out_free) begin
			out_v_q   <= v0_q;
			out_w_q   <= w0_q;
			out_sat_q <= sat_q;
		end
		if (run) begin
			case (uop.kind)
				K_MUL: p_q <= prod;
				K_D6: begin
					nq_q   <= {2'b00, dsum[58:25]};
					rem_q  <= '0;
					dsat_q <= d_sat;
					dneg_q <= dsum[65];
				end
				K_DIV: begin
					nq_q  <= nq_next;
					rem_q <= rem_next;
				end
				default: ;
			endcase
			case (uop.dst)
				D_MV:    mv_q <= res_val;
				D_MW:    mw_q <= res_val;
				D_KV:    kv_q <= res_val;
				D_KW:    kw_q <= res_val;
				D_SV:    sv_q <= res_val;
				D_SW:    sw_q <= res_val;
				D_T1:    t1_q <= res_val;
				D_T2:    t2_q <= res_val;
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/core/fnr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnr_checker
// Port-level checks of the RK4 step block, bound to the top level.
// ----------------------------------------------------------------------------
module fnr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        stim_valid,
	input logic        stim_ready,
	input logic        stim_op,
	input logic        stim_last_term,
	input logic        result_valid,
	input logic        result_ready,
	input logic [31:0] result_membrane,
	input logic [31:0] result_recovery,
	input logic        result_saturated
);
	logic stim_acc;
	assign stim_acc = stim_valid && stim_ready;

	// a last term starts a step and takes ready low
	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(stim_acc && !stim_op && stim_last_term) |=> !stim_ready)
		else $error("ready stayed high after a step request");

	// restarts and plain terms leave ready high
	a_term_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(stim_acc && (stim_op || !stim_last_term)) |=> stim_ready)
		else $error("ready dropped after a one-cycle request");

	// a new result only comes out of a running step
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(!stim_ready))
		else $error("result appeared while idle");

	a_no_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		stim_acc |=> !$rose(result_valid))
		else $error("result appeared right after a request");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> (result_valid && $stable(result_membrane)
			&& $stable(result_recovery) && $stable(result_saturated)))
		else $error("stalled result changed");

endmodule

bind fitzhugh_nagumo_rk4_step fnr_checker u_fnr_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.stim_valid       (stim.valid),
	.stim_ready       (stim.ready),
	.stim_op          (stim.op),
	.stim_last_term   (stim.last_term),
	.result_valid     (result.valid),
	.result_ready     (result.ready),
	.result_membrane  (result.membrane),
	.result_recovery  (result.recovery),
	.result_saturated (result.saturated)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the FitzHugh-Nagumo RK4 step block. Stimulus bursts,
// restarts and malformed requests run under several register settings and
// flow-control patterns; each result is checked against a bit-exact Q8.24
// RK4 predictor kept alongside the block.
// ----------------------------------------------------------------------------
import fnr_pkg::*;

typedef enum logic {
	OP_TERM    = 1'b0,
	OP_RESTART = 1'b1
} req_op_t;

typedef enum int {
	CFG_TYPICAL,
	CFG_MODERATE,
	CFG_WILD,
	CFG_EXTREME
} cfg_plan_t;

typedef enum int {
	FLOW_FREE,
	FLOW_SRC_IDLE,
	FLOW_SNK_STALL,
	FLOW_BOTH
} flow_t;

typedef struct {
	logic signed [DATA_W-1:0] membrane;
	logic signed [DATA_W-1:0] recovery;
	logic                     saturated;
} neuron_out_t;

class rk4_scoreboard;
	localparam longint Q_ONE = 64'd16777216;
	localparam longint HI    = longint'(S32_MAX);
	localparam longint LO    = longint'(S32_MIN);

	longint      coef_a, coef_b, inv_tau, step_size, init_v, init_w;
	longint      v_now, w_now, stim_sum;
	bit          sat_seen;
	neuron_out_t due_steps[$];
	int unsigned errors;
	int unsigned results_seen;

	function new();
		coef_a       = 0;
		coef_b       = 0;
		inv_tau      = longint'(INV_TAU_RST);
		step_size    = longint'(STEP_SIZE_RST);
		init_v       = 0;
		init_w       = 0;
		v_now        = 0;
		w_now        = 0;
		stim_sum     = 0;
		errors       = 0;
		results_seen = 0;
	endfunction

	function int pending();
		return due_steps.size();
	endfunction

	function longint clamp(longint x);
		if (x > HI) begin
			sat_seen = 1'b1;
			return HI;
		end
		if (x < LO) begin
			sat_seen = 1'b1;
			return LO;
		end
		return x;
	endfunction

	function longint sat_add(longint x, longint y);
		return clamp(x + y);
	endfunction

	function longint sat_sub(longint x, longint y);
		return clamp(x - y);
	endfunction

	// p / d, nearest, ties away from zero, saturated
	function longint round_div(longint p, longint d);
		longint m, q;
		m = (p < 0) ? -p : p;
		q = (m + d / 2) / d;
		if (p < 0) begin
			if (q > -LO) begin
				sat_seen = 1'b1;
				return LO;
			end
			return -q;
		end
		if (q > HI) begin
			sat_seen = 1'b1;
			return HI;
		end
		return q;
	endfunction

	function longint qmul(longint x, longint y);
		return round_div(x * y, Q_ONE);
	endfunction

	function longint dv_dt(longint v, longint w, longint s);
		longint cube;
		cube = qmul(qmul(v, v), v);
		return sat_add(sat_sub(sat_sub(v, cube), w), s);
	endfunction

	function longint dw_dt(longint v, longint w);
		longint t;
		t = sat_sub(sat_add(v, coef_a), qmul(coef_b, w));
		return qmul(t, inv_tau);
	endfunction

	function neuron_out_t advance();
		neuron_out_t r;
		longint v, w, h, s, mv, mw, sv, sw;
		longint k1v, k1w, k2v, k2w, k3v, k3w, k4v, k4w;
		sat_seen = 1'b0;
		v = v_now;
		w = w_now;
		h = step_size;
		s = stim_sum;
		k1v = dv_dt(v, w, s);
		k1w = dw_dt(v, w);
		mv  = sat_add(v, round_div(k1v * h, 2 * Q_ONE));
		mw  = sat_add(w, round_div(k1w * h, 2 * Q_ONE));
		k2v = dv_dt(mv, mw, s);
		k2w = dw_dt(mv, mw);
		mv  = sat_add(v, round_div(k2v * h, 2 * Q_ONE));
		mw  = sat_add(w, round_div(k2w * h, 2 * Q_ONE));
		k3v = dv_dt(mv, mw, s);
		k3w = dw_dt(mv, mw);
		mv  = sat_add(v, qmul(k3v, h));
		mw  = sat_add(w, qmul(k3w, h));
		k4v = dv_dt(mv, mw, s);
		k4w = dw_dt(mv, mw);
		sv  = sat_add(sat_add(sat_add(sat_add(sat_add(k1v, k2v), k2v), k3v), k3v), k4v);
		sw  = sat_add(sat_add(sat_add(sat_add(sat_add(k1w, k2w), k2w), k3w), k3w), k4w);
		v   = sat_add(v, round_div(sv * h, 6 * Q_ONE));
		w   = sat_add(w, round_div(sw * h, 6 * Q_ONE));
		v_now    = v;
		w_now    = w;
		stim_sum = 0;
		r.membrane  = v[DATA_W-1:0];
		r.recovery  = w[DATA_W-1:0];
		r.saturated = sat_seen;
		return r;
	endfunction

	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		case (idx)
			CFG_COEF_A:    coef_a    = longint'($signed(data));
			CFG_COEF_B:    coef_b    = longint'($signed(data));
			CFG_INV_TAU:   inv_tau   = longint'(data & 32'h7FFF_FFFF);
			CFG_STEP_SIZE: step_size = longint'(data & 32'h7FFF_FFFF);
			CFG_INIT_V:    init_v    = longint'($signed(data));
			CFG_INIT_W:    init_w    = longint'($signed(data));
			default: ;
		endcase
	endfunction

	function void note_request(logic op, logic [DATA_W-1:0] term, logic last);
		if (op == OP_RESTART) begin
			v_now    = init_v;
			w_now    = init_w;
			stim_sum = 0;
			return;
		end
		// sum overflow is silent: the flag is cleared at the start of each step
		stim_sum = clamp(stim_sum + longint'($signed(term)));
		if (last)
			due_steps.push_back(advance());
	endfunction

	function void check_result(logic signed [DATA_W-1:0] membrane,
			logic signed [DATA_W-1:0] recovery, logic saturated);
		neuron_out_t e;
		results_seen++;
		if (due_steps.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("result %0d unexpected: membrane %h recovery %h saturated %b",
					results_seen, membrane, recovery, saturated);
			return;
		end
		e = due_steps.pop_front();
		if (e.membrane !== membrane || e.recovery !== recovery
				|| e.saturated !== saturated) begin
			errors++;
			if (errors <= 10)
				$display({"result %0d mismatch: membrane exp %h got %h, ",
					"recovery exp %h got %h, saturated exp %b got %b"},
					results_seen, e.membrane, membrane, e.recovery, recovery,
					e.saturated, saturated);
		end
	endfunction
endclass

module testbench;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	localparam int STEP_CYCLES     = 107;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 219;
	localparam int PRESSURE_PHASE  = 4;
	localparam int HOLD_OFF_CYCLES = 1500;

	localparam cfg_plan_t CFG_PLAN [PHASES] = '{CFG_TYPICAL, CFG_MODERATE, CFG_TYPICAL,
		CFG_EXTREME, CFG_MODERATE, CFG_WILD, CFG_TYPICAL, CFG_EXTREME};
	localparam flow_t FLOW_PLAN [PHASES] = '{FLOW_FREE, FLOW_SRC_IDLE, FLOW_SNK_STALL,
		FLOW_BOTH, FLOW_FREE, FLOW_SRC_IDLE, FLOW_SNK_STALL, FLOW_BOTH};

	// Q8.24 constants
	localparam logic [DATA_W-1:0] Q_ONE_P   = 32'h0100_0000;
	localparam logic [DATA_W-1:0] Q_HALF    = 32'h0080_0000;
	localparam logic [DATA_W-1:0] Q_QUARTER = 32'h0040_0000;
	localparam logic [DATA_W-1:0] Q_M_HALF  = 32'hFF80_0000;
	localparam logic [DATA_W-1:0] Q_M_ONE   = 32'hFF00_0000;
	localparam logic [DATA_W-1:0] A_TYP     = 32'd11744051;   // 0.7
	localparam logic [DATA_W-1:0] B_TYP     = 32'd13421773;   // 0.8
	localparam logic [DATA_W-1:0] TAU_TYP   = 32'd1342177;    // 1 / 12.5
	localparam logic [DATA_W-1:0] DT_TYP    = 32'd838861;     // 0.05
	localparam logic [DATA_W-1:0] U31_MAX   = 32'h7FFF_FFFF;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	fnr_in_if  stim_ch();
	fnr_out_if res_ch();

	rk4_scoreboard board = new();

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_req       = 0;
	int phase_items    = 0;

	fitzhugh_nagumo_rk4_step dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.stim      (stim_ch),
		.result    (res_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// result sink: random stalls plus one long hold-off on request
	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
				board.check_result(res_ch.membrane, res_ch.recovery, res_ch.saturated);
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				res_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	task automatic send_req(input logic op, input logic [DATA_W-1:0] term, input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			stim_ch.valid <= 1'b0;
			@(posedge clk);
		end
		stim_ch.valid     <= 1'b1;
		stim_ch.op        <= op;
		stim_ch.term      <= term;
		stim_ch.last_term <= last;
		@(posedge clk);
		while (stim_ch.ready !== 1'b1)
			@(posedge clk);
		board.note_request(op, term, last);
		phase_items++;
	endtask

	// uniform in [-span, span], two's complement
	function automatic logic [DATA_W-1:0] near_zero(input int unsigned span);
		return $urandom_range(0, 2 * span) - span;
	endfunction

	function automatic logic [DATA_W-1:0] pick_term();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return near_zero(32'h0200_0000);
		if (r < 90)
			return $urandom;
		case ($urandom_range(0, 3))
			0:       return S32_MAX;
			1:       return S32_MIN;
			2:       return '0;
			default: return '1;
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_signed_edge();
		case ($urandom_range(0, 2))
			0:       return S32_MAX;
			1:       return S32_MIN;
			default: return '0;
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_unsigned_edge();
		case ($urandom_range(0, 2))
			0:       return U31_MAX;
			1:       return '1;      // top bit is dropped by the register
			default: return '0;
		endcase
	endfunction

	// mostly complete bursts, some restarts, some random garbage
	task automatic send_burst();
		int n;
		if ($urandom_range(0, 99) < 85) begin
			if ($urandom_range(0, 19) == 0)
				send_req(OP_RESTART, $urandom, 1'($urandom_range(0, 1)));
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++)
				send_req(OP_TERM, pick_term(), i == n - 1);
		end else begin
			send_req(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		board.write_reg(idx, data);
	endtask

	task automatic load_config(input logic [CFG_W-1:0] a, input logic [CFG_W-1:0] b,
			input logic [CFG_W-1:0] tau, input logic [CFG_W-1:0] dt,
			input logic [CFG_W-1:0] iv, input logic [CFG_W-1:0] iw);
		write_reg(CFG_SPARE_LO, $urandom);
		write_reg(CFG_COEF_A, a);
		write_reg(CFG_COEF_B, b);
		write_reg(CFG_INV_TAU, tau);
		write_reg(CFG_STEP_SIZE, dt);
		write_reg(CFG_INIT_V, iv);
		write_reg(CFG_INIT_W, iw);
		write_reg(CFG_SPARE_HI, $urandom);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_config(input cfg_plan_t plan);
		case (plan)
			CFG_TYPICAL: begin
				load_config(A_TYP, B_TYP, TAU_TYP, $urandom_range(167772, 1677722),
					near_zero(32'h0200_0000), near_zero(32'h0200_0000));
			end
			CFG_MODERATE: begin
				load_config(near_zero(32'h0200_0000), near_zero(32'h0200_0000),
					$urandom_range(0, 32'h0100_0000), $urandom_range(0, 32'h0080_0000),
					near_zero(32'h0200_0000), near_zero(32'h0200_0000));
			end
			CFG_WILD: begin
				load_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			end
			default: begin
				load_config(pick_signed_edge(), pick_signed_edge(), pick_unsigned_edge(),
					pick_unsigned_edge(), pick_signed_edge(), pick_signed_edge());
			end
		endcase
	endtask

	// wait out all expected results, then let any request in flight finish
	task automatic settle();
		while (board.pending() != 0)
			@(posedge clk);
		repeat (STEP_CYCLES + 13) @(posedge clk);
	endtask

	initial begin : stimulus
		bit held;
		held              = 1'b0;
		arst_n            <= 1'b0;
		cfg_wr_en         <= 1'b0;
		cfg_index         <= '0;
		cfg_data          <= '0;
		stim_ch.valid     <= 1'b0;
		stim_ch.op        <= OP_TERM;
		stim_ch.term      <= '0;
		stim_ch.last_term <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values
		send_req(OP_TERM, '0, 1'b1);
		send_req(OP_TERM, S32_MAX, 1'b0);        // sum at the maximum; the next term overflows it, flag untouched
		send_req(OP_TERM, S32_MAX, 1'b1);
		send_req(OP_TERM, S32_MIN, 1'b0);
		send_req(OP_TERM, S32_MIN, 1'b1);
		send_req(OP_TERM, Q_ONE_P, 1'b0);
		send_req(OP_TERM, Q_M_HALF, 1'b0);
		send_req(OP_TERM, Q_QUARTER, 1'b1);
		send_req(OP_RESTART, 32'hAAAA_AAAA, 1'b1); // term and last mark ignored
		send_req(OP_TERM, Q_HALF, 1'b1);
		send_req(OP_TERM, 32'h5555_5555, 1'b1);
		send_req(OP_TERM, 32'hAAAA_AAAA, 1'b1);
		stim_ch.valid <= 1'b0;
		settle();

		load_config(A_TYP, B_TYP, TAU_TYP, DT_TYP, Q_M_ONE, Q_HALF);
		send_req(OP_RESTART, '0, 1'b0);
		send_req(OP_TERM, Q_HALF, 1'b1);
		send_req(OP_TERM, '0, 1'b0);
		send_req(OP_TERM, Q_QUARTER, 1'b1);
		stim_ch.valid <= 1'b0;
		settle();

		load_config(S32_MIN, S32_MAX, U31_MAX, U31_MAX, S32_MAX, S32_MIN);
		send_req(OP_RESTART, '1, 1'b0);
		send_req(OP_TERM, '0, 1'b1);
		send_req(OP_TERM, S32_MIN, 1'b1);
		stim_ch.valid <= 1'b0;
		settle();

		load_config(S32_MAX, S32_MIN, '0, '0, S32_MIN, S32_MAX);
		send_req(OP_RESTART, '0, 1'b1);
		send_req(OP_TERM, Q_ONE_P, 1'b1);
		send_req(OP_TERM, S32_MAX, 1'b1);
		stim_ch.valid <= 1'b0;

		for (int p = 0; p < PHASES; p++) begin
			settle();
			random_config(CFG_PLAN[p]);
			case (FLOW_PLAN[p])
				FLOW_FREE: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				FLOW_SRC_IDLE: begin
					send_idle_pct  = 61;
					recv_stall_pct = 0;
				end
				FLOW_SNK_STALL: begin
					send_idle_pct  = 0;
					recv_stall_pct = 61;
				end
				default: begin
					send_idle_pct  = 12;
					recv_stall_pct = 12;
				end
			endcase
			phase_items = 0;
			send_req(OP_RESTART, $urandom, 1'($urandom_range(0, 1)));
			while (phase_items < ITEMS_PER_PHASE) begin
				// sink holds off while requests keep coming, backing up the block
				if (p == PRESSURE_PHASE && phase_items >= 60 && !held) begin
					hold_req = HOLD_OFF_CYCLES;
					held     = 1'b1;
				end
				send_burst();
			end
			stim_ch.valid <= 1'b0;
		end

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		settle();
		if (board.errors == 0 && board.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
